/* rtl/eesf_pkg.sv */
// Package for the exact envelope segment fitter.
// Holds widths, controller state type and the command/status structs.
package eesf_pkg;

  localparam int MaxTicksDef  = 256;
  localparam int MaxPointsDef = 12;
  localparam int ValW         = 7;
  localparam int CfgW         = 9;
  localparam int TickOutW     = 8;

  localparam logic [0:0] CfgLoop    = 1'b0;
  localparam logic [0:0] CfgRelease = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEG_INIT,
    ST_SEG_A,
    ST_RD_END,
    ST_CAP_E,
    ST_RD_K,
    ST_CMP,
    ST_COMMIT,
    ST_EMIT_PT,
    ST_EMIT_RD,
    ST_EMIT,
    ST_FAIL
  } state_e;

  typedef struct packed {
    logic load;
    logic seg_init;
    logic cap_a;
    logic rd_end;
    logic cap_e;
    logic rd_k;
    logic k_next;
    logic accept_end;
    logic commit;
    logic emit_pt;
    logic emit_rd;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic seg_done;
    logic end_at_len;
    logic k_at_end;
    logic k_kept;
    logic on_line;
    logic overflow;
    logic emit_last;
  } sts_t;

endpackage

/* rtl/eesf_datapath.sv */
// Datapath of the envelope segment fitter: tick store, point store,
// a multiply-compare line test and the segment search counters. Uses eesf_pkg.
module eesf_datapath #(
  parameter int MaxTicks  = eesf_pkg::MaxTicksDef,
  parameter int MaxPoints = eesf_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eesf_pkg::cmd_t                cmd_i,
  output eesf_pkg::sts_t                sts_o,
  input  logic [eesf_pkg::ValW-1:0]     sample_value_i,
  input  logic                          last_sample_i,
  input  logic signed [eesf_pkg::CfgW-1:0] loop_tick_i,
  input  logic signed [eesf_pkg::CfgW-1:0] release_tick_i,
  output logic [eesf_pkg::TickOutW-1:0] point_tick_o,
  output logic [eesf_pkg::ValW-1:0]     point_value_o,
  output logic                          is_loop_point_o,
  output logic                          is_release_point_o,
  output logic                          last_point_o
);
  localparam int AW  = $clog2(MaxTicks);
  localparam int CW  = $clog2(MaxTicks + 1);
  localparam int PAW = $clog2(MaxPoints);
  localparam int PCW = $clog2(MaxPoints + 2);
  localparam int KW  = (CW > eesf_pkg::CfgW) ? CW : eesf_pkg::CfgW;
  localparam int MW  = eesf_pkg::ValW + CW + 4;

  logic [eesf_pkg::ValW-1:0] tick_mem [MaxTicks];
  logic [AW-1:0]             pt_mem [MaxPoints];

  logic [CW-1:0]  cnt_q, cnt_d, len_q;
  logic [CW-1:0]  start_q, end_q, best_q, k_q;
  logic [PCW-1:0] n_q, ei_q;
  logic [eesf_pkg::ValW-1:0] a_q, e_val_q, rd_q;
  logic [AW-1:0]  et_q;
  logic [AW-1:0]  rd_addr;
  logic           rd_en;
  logic           end_at_len;

  assign cnt_d = (cnt_q < CW'(MaxTicks)) ? cnt_q + CW'(1) : cnt_q;
  assign end_at_len = (end_q >= len_q);

  always_comb begin
    rd_addr = et_q;
    if (cmd_i.seg_init) begin
      rd_addr = start_q[AW-1:0];
    end else if (cmd_i.rd_end) begin
      rd_addr = end_q[AW-1:0];
    end else if (cmd_i.rd_k) begin
      rd_addr = k_q[AW-1:0];
    end
  end

  assign rd_en = cmd_i.seg_init || (cmd_i.rd_end && !end_at_len) || cmd_i.rd_k ||
                 cmd_i.emit_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q < CW'(MaxTicks)) begin
      tick_mem[cnt_q[AW-1:0]] <= sample_value_i;
    end
    if (rd_en) begin
      rd_q <= tick_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && last_sample_i) begin
      pt_mem[0] <= '0;
    end
    if (cmd_i.commit && n_q < PCW'(MaxPoints)) begin
      pt_mem[n_q[PAW-1:0]] <= best_q[AW-1:0];
    end
    if (cmd_i.emit_pt) begin
      et_q <= pt_mem[ei_q[PAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      len_q   <= '0;
      start_q <= '0;
      end_q   <= '0;
      best_q  <= '0;
      k_q     <= '0;
      n_q     <= '0;
      ei_q    <= '0;
      a_q     <= '0;
      e_val_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= last_sample_i ? CW'(0) : cnt_d;
        if (last_sample_i) begin
          len_q   <= cnt_d;
          start_q <= '0;
          n_q     <= PCW'(1);
          ei_q    <= '0;
        end
      end
      if (cmd_i.seg_init) begin
        best_q <= start_q + CW'(1);
        end_q  <= start_q + CW'(1);
      end
      if (cmd_i.cap_a) a_q <= rd_q;
      if (cmd_i.rd_end) k_q <= start_q + CW'(1);
      if (cmd_i.cap_e) e_val_q <= rd_q;
      if (cmd_i.k_next) k_q <= k_q + CW'(1);
      if (cmd_i.accept_end) begin
        best_q <= end_q;
        end_q  <= end_q + CW'(1);
      end
      if (cmd_i.commit) begin
        if (n_q <= PCW'(MaxPoints)) n_q <= n_q + PCW'(1);
        start_q <= best_q;
      end
      if (cmd_i.emit_next) ei_q <= ei_q + PCW'(1);
    end
  end

  // The truncated quotient equals the deviation exactly when the product
  // lies in the span-wide window next to deviation * span, on its sign's side.
  logic signed [eesf_pkg::ValW+1:0] diff, dev;
  logic [CW-1:0]                    off, span;
  logic signed [MW-1:0]             prod, lo, spw;
  logic                             on_line;
  assign diff = $signed({2'b00, e_val_q}) - $signed({2'b00, a_q});
  assign dev  = $signed({2'b00, rd_q}) - $signed({2'b00, a_q});
  assign off  = k_q - start_q;
  assign span = end_q - start_q;
  assign spw  = MW'($signed({1'b0, span}));
  assign prod = MW'(diff) * MW'($signed({1'b0, off}));
  assign lo   = MW'(dev) * spw;
  assign on_line = prod[MW-1] ? ((prod > lo - spw) && (prod <= lo))
                              : ((prod >= lo) && (prod < lo + spw));

  logic k_loop, k_rel;
  assign k_loop = !loop_tick_i[eesf_pkg::CfgW-1] &&
                  (KW'(k_q) == KW'(unsigned'(loop_tick_i)));
  assign k_rel  = !release_tick_i[eesf_pkg::CfgW-1] &&
                  (KW'(k_q) == KW'(unsigned'(release_tick_i)));

  always_comb begin
    sts_o.last_in    = last_sample_i;
    sts_o.seg_done   = (start_q + CW'(1) >= len_q);
    sts_o.end_at_len = end_at_len;
    sts_o.k_at_end   = (k_q >= end_q);
    sts_o.k_kept     = (k_q == CW'(0)) || (k_q == len_q - CW'(1)) || k_loop || k_rel;
    sts_o.on_line    = on_line;
    sts_o.overflow   = (n_q > PCW'(MaxPoints));
    sts_o.emit_last  = (ei_q + PCW'(1) == n_q);
  end

  assign point_tick_o       = eesf_pkg::TickOutW'(et_q);
  assign point_value_o      = rd_q;
  assign is_loop_point_o    = !loop_tick_i[eesf_pkg::CfgW-1] &&
                              (KW'(et_q) == KW'(unsigned'(loop_tick_i)));
  assign is_release_point_o = !release_tick_i[eesf_pkg::CfgW-1] &&
                              (KW'(et_q) == KW'(unsigned'(release_tick_i)));
  assign last_point_o       = sts_o.emit_last;
endmodule

/* rtl/eesf_ctrl.sv */
// Controller of the envelope segment fitter: sequences load, search,
// line checks, commit and emission. Uses eesf_pkg.
module eesf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           fail_o,
  output eesf_pkg::cmd_t cmd_o,
  input  eesf_pkg::sts_t sts_i
);
  eesf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eesf_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      eesf_pkg::ST_LOAD:     if (in_acc && sts_i.last_in) state_d = eesf_pkg::ST_SEG_INIT;
      eesf_pkg::ST_SEG_INIT: begin
        if (sts_i.overflow) state_d = eesf_pkg::ST_FAIL;
        else if (sts_i.seg_done) state_d = eesf_pkg::ST_EMIT_PT;
        else state_d = eesf_pkg::ST_SEG_A;
      end
      eesf_pkg::ST_SEG_A:    state_d = eesf_pkg::ST_RD_END;
      eesf_pkg::ST_RD_END:   state_d = sts_i.end_at_len ? eesf_pkg::ST_COMMIT
                                                        : eesf_pkg::ST_CAP_E;
      eesf_pkg::ST_CAP_E:    state_d = eesf_pkg::ST_RD_K;
      eesf_pkg::ST_RD_K: begin
        if (sts_i.k_at_end) state_d = eesf_pkg::ST_RD_END;
        else if (sts_i.k_kept) state_d = eesf_pkg::ST_COMMIT;
        else state_d = eesf_pkg::ST_CMP;
      end
      eesf_pkg::ST_CMP:      state_d = sts_i.on_line ? eesf_pkg::ST_RD_K
                                                     : eesf_pkg::ST_COMMIT;
      eesf_pkg::ST_COMMIT:   state_d = eesf_pkg::ST_SEG_INIT;
      eesf_pkg::ST_EMIT_PT:  state_d = eesf_pkg::ST_EMIT_RD;
      eesf_pkg::ST_EMIT_RD:  state_d = eesf_pkg::ST_EMIT;
      eesf_pkg::ST_EMIT: begin
        if (!out_stall_i) state_d = sts_i.emit_last ? eesf_pkg::ST_LOAD
                                                    : eesf_pkg::ST_EMIT_PT;
      end
      eesf_pkg::ST_FAIL:     if (!out_stall_i) state_d = eesf_pkg::ST_LOAD;
      default:               state_d = eesf_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    fail_o      = 1'b0;
    case (state_q)
      eesf_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      eesf_pkg::ST_SEG_INIT: cmd_o.seg_init = 1'b1;
      eesf_pkg::ST_SEG_A:    cmd_o.cap_a = 1'b1;
      eesf_pkg::ST_RD_END:   cmd_o.rd_end = 1'b1;
      eesf_pkg::ST_CAP_E:    cmd_o.cap_e = 1'b1;
      eesf_pkg::ST_RD_K: begin
        cmd_o.rd_k       = 1'b1;
        cmd_o.accept_end = sts_i.k_at_end;
      end
      eesf_pkg::ST_CMP:      cmd_o.k_next = sts_i.on_line;
      eesf_pkg::ST_COMMIT:   cmd_o.commit = 1'b1;
      eesf_pkg::ST_EMIT_PT:  cmd_o.emit_pt = 1'b1;
      eesf_pkg::ST_EMIT_RD:  cmd_o.emit_rd = 1'b1;
      eesf_pkg::ST_EMIT: begin
        out_valid_o     = 1'b1;
        cmd_o.emit_next = !out_stall_i;
      end
      eesf_pkg::ST_FAIL: begin
        out_valid_o = 1'b1;
        fail_o      = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end
endmodule

/* rtl/exact_envelope_segment_fitter_unit.sv */
// Top level of the exact envelope segment fitter.
// Holds the configuration registers; instantiates eesf_ctrl and eesf_datapath.
//
//  channel | handshake               | payload
//  input   | in_valid_i/in_stall_o   | sample_value_i, last_sample_i
//  output  | out_valid_o/out_stall_i | point_tick_o .. fit_failed_o
//  config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// Ticks load at one a cycle while the block is idle; the input stalls from the last tick
// until the final beat is taken. A segment opens in SEG_INIT and SEG_A, reads each
// candidate end in RD_END and CAP_E, checks interior ticks in RD_K and CMP and commits.
// Points go out via EMIT_PT, EMIT_RD and EMIT, a failure as one beat. Async reset clears
// counters and most registers but not the stores; an output stall holds the current beat.
module exact_envelope_segment_fitter_unit #(
  parameter int MaxTicks  = eesf_pkg::MaxTicksDef,
  parameter int MaxPoints = eesf_pkg::MaxPointsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [eesf_pkg::ValW-1:0]     sample_value_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [eesf_pkg::TickOutW-1:0] point_tick_o,
  output logic [eesf_pkg::ValW-1:0]     point_value_o,
  output logic                          is_loop_point_o,
  output logic                          is_release_point_o,
  output logic                          last_point_o,
  output logic                          fit_failed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [eesf_pkg::CfgW-1:0]     cfg_data_i
);
  logic signed [eesf_pkg::CfgW-1:0] loop_q, rel_q;
  eesf_pkg::cmd_t cmd;
  eesf_pkg::sts_t sts;
  logic fail;
  logic [eesf_pkg::TickOutW-1:0] pt;
  logic [eesf_pkg::ValW-1:0] pv;
  logic il, ir, lp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q <= '1;
      rel_q  <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == eesf_pkg::CfgLoop) loop_q <= cfg_data_i;
      if (cfg_index_i == eesf_pkg::CfgRelease) rel_q <= cfg_data_i;
    end
  end

  eesf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .fail_o(fail), .cmd_o(cmd), .sts_i(sts)
  );

  eesf_datapath #(.MaxTicks(MaxTicks), .MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .sample_value_i, .last_sample_i,
    .loop_tick_i(loop_q), .release_tick_i(rel_q), .point_tick_o(pt),
    .point_value_o(pv), .is_loop_point_o(il), .is_release_point_o(ir),
    .last_point_o(lp)
  );

  assign point_tick_o       = fail ? '0 : pt;
  assign point_value_o      = fail ? '0 : pv;
  assign is_loop_point_o    = !fail && il;
  assign is_release_point_o = !fail && ir;
  assign last_point_o       = fail || lp;
  assign fit_failed_o       = fail;
endmodule
